@@ hw/rtl/ordered_array_table_top_assert.svh @@
// Assertion macros for the ordered array table RTL, included by oat_ctrl.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef ORDERED_ARRAY_TABLE_TOP_ASSERT_SVH
`define ORDERED_ARRAY_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OAT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered array table assertion failed");

// Next-cycle implication, checked outside reset.
`define OAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered array table assertion failed");

`endif

@@ hw/rtl/oat_pkg.sv @@
// Package for the ordered array table: beat types, codes and cell commands.
// No dependencies.
package oat_pkg;

   localparam int DEPTH_DEFAULT      = 32;
   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int POS_W              = 6;
   localparam int IDX_W              = 6;
   localparam int FIELD_W            = 32;

   localparam logic [2:0] FN_INSERT = 3'd0;
   localparam logic [2:0] FN_DELETE = 3'd1;
   localparam logic [2:0] FN_SEARCH = 3'd2;
   localparam logic [2:0] FN_UPDATE = 3'd3;
   localparam logic [2:0] FN_DUMP   = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [2:0]                func;
      logic [POS_W-1:0]          position;
      logic signed [FIELD_W-1:0] value;
      logic signed [FIELD_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]                status;
      logic [POS_W-1:0]          found_position;
      logic signed [FIELD_W-1:0] entry_value;
      logic [POS_W-1:0]          entry_count;
      logic                      last;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_WRITE,
      CELL_ROTATE,
      CELL_MATCH
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] sel;
   } cell_cmd_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } hit_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC,
      S_DUMP
   } ctrl_state_type;

endpackage

@@ hw/rtl/ordered_array_table_top.sv @@
// Ordered array table: top level with the cell chain and the sequencer.
// Depends on oat_pkg, oat_cell and oat_ctrl.
// The table is a chain of DEPTH cells, each holding one word; insert and delete shift
// the cells past the given position by one place together, and search or update compare
// every cell at once. Each request beat is accepted, compared into the match registers,
// and has its first hit selected and executed once the result register is free; dump
// sends one beat per entry held while that register is free, the chain rotating one
// place a cycle towards cell zero, which drives each dumped value. A result waiting on
// rsp_ does not block the next request beat. Entries need no clearing after reset.
module ordered_array_table_top #(
   parameter int DEPTH      = oat_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH = oat_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  oat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output oat_pkg::rsp_type rsp_data
);
   import oat_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_cmd_type                 cmd;
   logic signed [WORD_WIDTH-1:0] cmd_word;
   logic [CNT_W-1:0]             count;
   logic signed [WORD_WIDTH-1:0] entry [DEPTH];
   logic [DEPTH-1:0]             match;
   logic [DEPTH-1:0]             hits;
   logic [DEPTH-1:0]             first;
   hit_type                      hit;
   logic signed [WORD_WIDTH-1:0] hit_word;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_WIDTH-1:0] left_word;
      logic signed [WORD_WIDTH-1:0] right_word;

      if (i == 0) begin : g_head
         assign left_word = cmd_word;
      end else begin : g_body
         assign left_word = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_word = cmd_word;
      end else begin : g_inner
         assign right_word = entry[i+1];
      end

      oat_cell #(
         .CELL_INDEX (i),
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cmd_word   (cmd_word),
         .left_word  (left_word),
         .right_word (right_word),
         .head_word  (entry[0]),
         .entry      (entry[i]),
         .match      (match[i])
      );

      assign hits[i] = match[i] && (CNT_W'(i) < count);
   end

   assign first = hits & (~hits + 1'b1);

   always_comb begin
      hit.found = |hits;
      hit.idx   = '0;
      hit_word  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            hit.idx  = hit.idx | IDX_W'(i);
            hit_word = hit_word | entry[i];
         end
      end
   end

   oat_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .cmd_word  (cmd_word),
      .count     (count),
      .hit       (hit),
      .hit_word  (hit_word),
      .head_word (entry[0])
   );

endmodule

@@ hw/rtl/oat_cell.sv @@
// One cell of the table chain: holds a word and its compare result.
// Depends on oat_pkg.
module oat_cell #(
   parameter int CELL_INDEX = 0,
   parameter int WORD_WIDTH = oat_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  oat_pkg::cell_cmd_type        cmd,
   input  logic signed [WORD_WIDTH-1:0] cmd_word,
   input  logic signed [WORD_WIDTH-1:0] left_word,
   input  logic signed [WORD_WIDTH-1:0] right_word,
   input  logic signed [WORD_WIDTH-1:0] head_word,
   output logic signed [WORD_WIDTH-1:0] entry,
   output logic                         match
);
   import oat_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic signed [WORD_WIDTH-1:0] entry_ff;
   logic signed [WORD_WIDTH-1:0] entry_in;
   logic                         match_ff;
   logic                         match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (MY_IDX == cmd.sel) begin
               entry_in = cmd_word;
            end else if (MY_IDX > cmd.sel) begin
               entry_in = left_word;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= cmd.sel) begin
               entry_in = right_word;
            end
         end
         CELL_WRITE: begin
            if (MY_IDX == cmd.sel) begin
               entry_in = cmd_word;
            end
         end
         CELL_ROTATE: begin
            if (MY_IDX == cmd.sel) begin
               entry_in = head_word;
            end else if (MY_IDX < cmd.sel) begin
               entry_in = right_word;
            end
         end
         CELL_MATCH: begin
            match_in = (entry_ff == cmd_word);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

@@ hw/rtl/oat_ctrl.sv @@
// Sequencer of the ordered array table: count, checks, cell commands, result register.
// Depends on oat_pkg and ordered_array_table_top_assert.svh.
module oat_ctrl #(
   parameter int DEPTH      = oat_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH = oat_pkg::WORD_WIDTH_DEFAULT,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  oat_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output oat_pkg::rsp_type             rsp_data,
   output oat_pkg::cell_cmd_type        cmd,
   output logic signed [WORD_WIDTH-1:0] cmd_word,
   output logic [CNT_W-1:0]             count,
   input  oat_pkg::hit_type             hit,
   input  logic signed [WORD_WIDTH-1:0] hit_word,
   input  logic signed [WORD_WIDTH-1:0] head_word
);
   import oat_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   ctrl_state_type               state_ff, state_in;
   logic [2:0]                   func_ff, func_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic signed [WORD_WIDTH-1:0] val_ff, val_in;
   logic signed [WORD_WIDTH-1:0] nval_ff, nval_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             dump_idx_ff, dump_idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                         out_free;
   logic                         dump_last;
   logic [CMP_W-1:0]             pos_cmp;
   logic [CMP_W-1:0]             cnt_cmp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dump_last = (CNT_W'(dump_idx_ff + 1'b1) == count_ff);
   assign pos_cmp   = CMP_W'(pos_ff);
   assign cnt_cmp   = CMP_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      nval_in      = nval_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd.op       = CELL_HOLD;
      cmd.sel      = '0;
      cmd_word     = val_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_data.func;
               pos_in  = req_data.position;
               val_in  = WORD_WIDTH'(req_data.value);
               nval_in = WORD_WIDTH'(req_data.new_value);
               if (req_data.func <= FN_DUMP) begin
                  state_in = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            cmd.op   = CELL_MATCH;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_OK;
               rsp_in.found_position = '0;
               rsp_in.entry_value    = '0;
               rsp_in.last           = 1'b1;
               state_in              = S_IDLE;
               priority case (func_ff)
                  FN_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        rsp_in.status = ST_FULL;
                     end else if (pos_ff == '0 || pos_cmp > cnt_cmp + 1'b1) begin
                        rsp_in.status = ST_BADPOS;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        cmd.sel  = IDX_W'(pos_ff - 1'b1);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FN_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (pos_ff == '0 || pos_cmp > cnt_cmp) begin
                        rsp_in.status = ST_BADPOS;
                     end else begin
                        cmd.op   = CELL_DELETE;
                        cmd.sel  = IDX_W'(pos_ff - 1'b1);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  FN_SEARCH, FN_UPDATE: begin
                     if (!hit.found) begin
                        rsp_in.status = ST_NOTFOUND;
                     end else begin
                        rsp_in.found_position = POS_W'(hit.idx) + 1'b1;
                        if (func_ff == FN_UPDATE) begin
                           cmd.op             = CELL_WRITE;
                           cmd.sel            = hit.idx;
                           cmd_word           = nval_ff;
                           rsp_in.entry_value = FIELD_W'(nval_ff);
                        end else begin
                           rsp_in.entry_value = FIELD_W'(hit_word);
                        end
                     end
                  end
                  FN_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        dump_idx_in  = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  end
               endcase
               rsp_in.entry_count = POS_W'(count_in);
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_OK;
               rsp_in.found_position = POS_W'(dump_idx_ff + 1'b1);
               rsp_in.entry_value    = FIELD_W'(head_word);
               rsp_in.entry_count    = POS_W'(count_ff);
               rsp_in.last           = dump_last;
               cmd.op                = CELL_ROTATE;
               cmd.sel               = IDX_W'(count_ff - 1'b1);
               dump_idx_in           = dump_idx_ff + 1'b1;
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      nval_ff <= nval_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign count     = count_ff;

`include "ordered_array_table_top_assert.svh"

   `OAT_ASSERT_NOW(a_count_in_range, 1'b1, count_ff <= FULL_COUNT)
   `OAT_ASSERT_NOW(a_no_insert_when_full, cmd.op == CELL_INSERT, count_ff < FULL_COUNT)
   `OAT_ASSERT_NEXT(a_count_moves_in_exec_only, state_ff != S_EXEC, $stable(count_ff))
   `OAT_ASSERT_NEXT(a_dump_ends_on_last, state_ff == S_DUMP && out_free && dump_last,
                    state_ff == S_IDLE && rsp_valid_ff && rsp_ff.last)

endmodule

@@ tb/sv/oat_table_monitor.sv @@
// Monitor for the ordered array table: watches both channels, keeps its own copy
// of the table, predicts every result beat and compares it with what the block sends.
// Depends on oat_pkg.
module oat_table_monitor #(
   parameter int DEPTH = oat_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  oat_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  oat_pkg::rsp_type rsp_data,
   output int               mismatch_total,
   output int               replies_pending
);
   import oat_pkg::*;

   logic signed [FIELD_W-1:0] held_words [DEPTH];
   int                        held_count;
   rsp_type                   replies_due [$];
   int                        errs;

   function automatic rsp_type make_reply(logic [2:0] st, int pos,
                                          logic signed [FIELD_W-1:0] word, logic fin);
      rsp_type r;
      r.status         = st;
      r.found_position = pos[POS_W-1:0];
      r.entry_value    = word;
      r.entry_count    = held_count[POS_W-1:0];
      r.last           = fin;
      return r;
   endfunction

   task automatic apply_table_op(req_type op);
      int slot;
      int hit;
      int i;
      slot = op.position;
      hit  = -1;
      case (op.func)
         FN_INSERT: begin
            if (held_count >= DEPTH) begin
               replies_due.push_back(make_reply(ST_FULL, 0, '0, 1'b1));
            end else if (slot < 1 || slot > held_count + 1) begin
               replies_due.push_back(make_reply(ST_BADPOS, 0, '0, 1'b1));
            end else begin
               for (i = held_count; i >= slot; i--) held_words[i] = held_words[i-1];
               held_words[slot-1] = op.value;
               held_count++;
               replies_due.push_back(make_reply(ST_OK, 0, '0, 1'b1));
            end
         end
         FN_DELETE: begin
            if (held_count == 0) begin
               replies_due.push_back(make_reply(ST_EMPTY, 0, '0, 1'b1));
            end else if (slot < 1 || slot > held_count) begin
               replies_due.push_back(make_reply(ST_BADPOS, 0, '0, 1'b1));
            end else begin
               for (i = slot - 1; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
               held_count--;
               replies_due.push_back(make_reply(ST_OK, 0, '0, 1'b1));
            end
         end
         FN_SEARCH, FN_UPDATE: begin
            for (i = 0; i < held_count; i++) begin
               if (hit < 0 && held_words[i] == op.value) hit = i;
            end
            if (hit < 0) begin
               replies_due.push_back(make_reply(ST_NOTFOUND, 0, '0, 1'b1));
            end else begin
               if (op.func == FN_UPDATE) held_words[hit] = op.new_value;
               replies_due.push_back(make_reply(ST_OK, hit + 1, held_words[hit], 1'b1));
            end
         end
         FN_DUMP: begin
            if (held_count == 0) begin
               replies_due.push_back(make_reply(ST_EMPTY, 0, '0, 1'b1));
            end else begin
               for (i = 0; i < held_count; i++) begin
                  replies_due.push_back(make_reply(ST_OK, i + 1, held_words[i],
                                                   i + 1 == held_count));
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_reply(rsp_type got);
      rsp_type want;
      if (replies_due.size() == 0) begin
         errs++;
         if (errs <= 10) begin
            $display("unexpected result beat: status %0d pos %0d value %0d count %0d last %0b",
                     got.status, got.found_position, got.entry_value, got.entry_count,
                     got.last);
         end
      end else begin
         want = replies_due.pop_front();
         if (got.status !== want.status || got.found_position !== want.found_position ||
             got.entry_value !== want.entry_value || got.entry_count !== want.entry_count ||
             got.last !== want.last) begin
            errs++;
            if (errs <= 10) begin
               $display("result mismatch: status %0d/%0d pos %0d/%0d value %0d/%0d",
                        want.status, got.status, want.found_position, got.found_position,
                        want.entry_value, got.entry_value);
               $display("   count %0d/%0d last %0b/%0b (expected/actual)",
                        want.entry_count, got.entry_count, want.last, got.last);
            end
         end
      end
   endtask

   initial errs = 0;

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_reply(rsp_data);
         if (req_valid && req_ready) apply_table_op(req_data);
      end
      mismatch_total  <= errs;
      replies_pending <= replies_due.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the ordered array table: clock, reset, stimulus and verdict.
// Depends on oat_pkg, ordered_array_table_top and oat_table_monitor.
module tb_top;
   import oat_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_total;
   int      replies_pending;
   int      send_idle_pct;
   int      take_idle_pct;
   int      hold_left;
   int      table_fill;
   int      ops_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   ordered_array_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   oat_table_monitor #(.DEPTH(TABLE_DEPTH)) monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatch_total  (mismatch_total),
      .replies_pending (replies_pending)
   );

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   function automatic logic signed [FIELD_W-1:0] pick_word();
      int r;
      r = $urandom_range(99);
      if (r < 60) return int'($urandom_range(9)) - 5;
      if (r < 75) begin
         case ($urandom_range(3))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_op(logic [2:0] fn, int slot, logic signed [FIELD_W-1:0] word,
                          logic signed [FIELD_W-1:0] repl);
      req_type beat;
      beat.func      = fn;
      beat.position  = slot[POS_W-1:0];
      beat.value     = word;
      beat.new_value = repl;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      if (fn == FN_INSERT && table_fill < TABLE_DEPTH && slot >= 1 && slot <= table_fill + 1)
         table_fill++;
      if (fn == FN_DELETE && table_fill > 0 && slot >= 1 && slot <= table_fill)
         table_fill--;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
   endtask

   task automatic random_op();
      int r;
      int slot;
      r = $urandom_range(99);
      if (r < 30) begin
         slot = ($urandom_range(99) < 85) ? $urandom_range(1, table_fill + 1)
                                          : $urandom_range(63);
         send_op(FN_INSERT, slot, pick_word(), pick_word());
      end else if (r < 58) begin
         slot = ($urandom_range(99) < 85 && table_fill > 0) ? $urandom_range(1, table_fill)
                                                            : $urandom_range(63);
         send_op(FN_DELETE, slot, pick_word(), pick_word());
      end else if (r < 74) begin
         send_op(FN_SEARCH, $urandom_range(63), pick_word(), pick_word());
      end else if (r < 88) begin
         send_op(FN_UPDATE, $urandom_range(63), pick_word(), pick_word());
      end else if (r < 95) begin
         send_op(FN_DUMP, $urandom_range(63), pick_word(), pick_word());
      end else begin
         send_op(3'($urandom_range(5, 7)), $urandom_range(63), $urandom, $urandom);
         ops_sent--;
      end
      ops_sent++;
   endtask

   task automatic run_random(int n);
      ops_sent = 0;
      while (ops_sent < n) random_op();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 19;
      take_idle_pct = 72;
      hold_left     = 0;
      table_fill    = 0;
      ops_sent      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_op(FN_DUMP, 0, 0, 0);
      send_op(FN_DELETE, 1, 0, 0);
      send_op(FN_SEARCH, 0, 7, 0);
      send_op(FN_UPDATE, 0, 7, 9);
      send_op(FN_INSERT, 0, 1, 0);
      send_op(FN_INSERT, 2, 1, 0);
      send_op(FN_INSERT, 1, 32'sh7fffffff, 0);
      send_op(FN_INSERT, 1, 32'sh80000000, 0);
      send_op(FN_INSERT, 3, 0, 0);
      send_op(FN_INSERT, 2, -1, 0);
      send_op(FN_INSERT, 63, 5, 0);
      send_op(FN_INSERT, 5, -1, 0);
      send_op(FN_SEARCH, 0, -1, 0);
      send_op(FN_SEARCH, 0, 32'sh7fffffff, 0);
      send_op(FN_UPDATE, 0, -1, 32'sh55aa55aa);
      send_op(FN_UPDATE, 0, 12345, 1);
      send_op(3'd5, 1, 2, 3);
      send_op(3'd6, 62, -2, -3);
      send_op(3'd7, 63, 32'sh7fffffff, 32'sh80000000);
      send_op(FN_DELETE, 0, 0, 0);
      send_op(FN_DELETE, 6, 0, 0);
      send_op(FN_DELETE, 1, 0, 0);
      send_op(FN_DELETE, 4, 0, 0);
      send_op(FN_DUMP, 63, 0, 0);

      while (table_fill < TABLE_DEPTH)
         send_op(FN_INSERT, $urandom_range(1, table_fill + 1), pick_word(), 0);
      send_op(FN_INSERT, 1, pick_word(), 0);
      send_op(FN_DUMP, 0, 0, 0);
      send_op(FN_UPDATE, 0, pick_word(), pick_word());
      while (table_fill > 0)
         send_op(FN_DELETE, $urandom_range(1, table_fill), 0, 0);
      send_op(FN_DUMP, 0, 0, 0);
      run_random(100);
      wait_for_results();

      send_idle_pct = 72;
      take_idle_pct = 19;
      run_random(170);
      wait_for_results();

      send_idle_pct = 0;
      take_idle_pct = 0;
      hold_left     = 400;
      run_random(170);
      wait_for_results();
      repeat (50) @(posedge clock);

      if (mismatch_total == 0 && replies_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
